// ===== hdl/sti_pkg.sv =====
// shared types and constants for the sorted table with insert and search
package sti_pkg;

  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 6;
  localparam int ENTRIES_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_MOVE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cell_cmp_t;

endpackage

// ===== hdl/sti_cell.sv =====
// one table cell: holds an entry, loads the key or shifts from its lower neighbor, compares with the key
module sti_cell (
  input  logic                               clk,
  input  sti_pkg::cell_ctl_t                 ctl,
  input  logic signed [sti_pkg::VALUE_W-1:0] shift_in,
  input  logic signed [sti_pkg::VALUE_W-1:0] key,
  output logic signed [sti_pkg::VALUE_W-1:0] entry,
  output sti_pkg::cell_cmp_t                 cmp
);
  import sti_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= key;
    end else if (ctl.shift) begin
      entry <= shift_in;
    end
  end

  assign cmp.gt = (entry > key);
  assign cmp.lt = (entry < key);

endmodule

// ===== hdl/sorted_table_insert_search.sv =====
// sorted table top level: control sequencer driving a chain of compare-and-shift cells
// sequence: insert passes a scan state and then a move state before its strobe; search passes probe states
//   (probes at most log2(DEPTH)+1, one table probe per cycle); clear/full/unused answer straight from idle
// busy is high while an item is in work; the next word is taken in the cycle its result shows
// synchronous reset empties the table and clears the mode register; cell contents are not reset
module sorted_table_insert_search #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sti_pkg::KIND_W-1:0]           kind,
  input  logic signed [sti_pkg::VALUE_W-1:0]   value,
  output logic                                 done,
  output logic [sti_pkg::STATUS_W-1:0]         status,
  output logic [sti_pkg::POS_W-1:0]            position,
  output logic [sti_pkg::ENTRIES_W-1:0]        entries,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);
  import sti_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  state_t                    state, state_next;
  logic                      desc;
  logic signed [VALUE_W-1:0] key, key_next;
  logic [CW-1:0]             fill, fill_next;
  logic signed [SW-1:0]      low, low_next;
  logic signed [SW-1:0]      high, high_next;
  logic [DEPTH-1:0]          nb, nb_next;
  logic                      done_next;
  logic [STATUS_W-1:0]       status_next;
  logic [POS_W-1:0]          position_next;
  logic [ENTRIES_W-1:0]      entries_next;

  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  cell_cmp_t                 cell_cmp [DEPTH];
  cell_ctl_t                 cell_ctl [DEPTH];
  logic [DEPTH-1:0]          keep_flag;
  logic [DEPTH-1:0]          hit;
  logic [DEPTH-1:0]          hit_gt;
  logic [DEPTH-1:0]          hit_lt;
  logic [AW-1:0]             ins_pos;
  logic signed [SW-1:0]      mid_w;
  logic [AW-1:0]             mid;
  logic                      e_after;
  logic                      v_after;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign mid_w   = (low + high) >>> 1;
  assign mid     = AW'(mid_w);
  assign e_after = desc ? (|hit_lt) : (|hit_gt);
  assign v_after = desc ? (|hit_gt) : (|hit_lt);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      sti_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[g]),
        .shift_in (key),
        .key      (key),
        .entry    (cell_val[g]),
        .cmp      (cell_cmp[g])
      );
    end else begin : g_rest
      sti_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[g]),
        .shift_in (cell_val[g-1]),
        .key      (key),
        .entry    (cell_val[g]),
        .cmp      (cell_cmp[g])
      );
    end

    assign keep_flag[g] = (CW'(g) < fill) &&
                          !(desc ? cell_cmp[g].lt : cell_cmp[g].gt);
    assign hit[g]       = (mid == AW'(g));
    assign hit_gt[g]    = hit[g] & cell_cmp[g].gt;
    assign hit_lt[g]    = hit[g] & cell_cmp[g].lt;

    assign cell_ctl[g].load  = (state == S_INS_MOVE) && (ins_pos == AW'(g));
    assign cell_ctl[g].shift = (state == S_INS_MOVE) && (AW'(g) > ins_pos) &&
                               (CW'(g) <= fill);
  end

  // insert point: one past the highest entry that stays in place
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (nb[i]) begin
        ins_pos = AW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
      desc  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        desc <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    low      <= low_next;
    high     <= high_next;
    nb       <= nb_next;
    status   <= status_next;
    position <= position_next;
    entries  <= entries_next;
  end

  always_comb begin
    state_next    = state;
    key_next      = key;
    fill_next     = fill;
    low_next      = low;
    high_next     = high;
    nb_next       = nb;
    done_next     = 1'b0;
    status_next   = status;
    position_next = position;
    entries_next  = entries;
    case (state)
      S_IDLE: begin
        if (start) begin
          key_next = value;
          case (kind)
            KIND_INSERT: begin
              if (fill == CW'(DEPTH)) begin
                done_next     = 1'b1;
                status_next   = ST_FULL;
                position_next = '0;
                entries_next  = ENTRIES_W'(fill);
              end else begin
                state_next = S_INS_SCAN;
              end
            end
            KIND_SEARCH: begin
              low_next  = '0;
              high_next = $signed(SW'(fill) - SW'(1));
              if (fill == '0) begin
                done_next     = 1'b1;
                status_next   = ST_NOT_FOUND;
                position_next = '0;
                entries_next  = '0;
              end else begin
                state_next = S_SEARCH;
              end
            end
            KIND_CLEAR: begin
              fill_next     = '0;
              done_next     = 1'b1;
              status_next   = ST_CLEARED;
              position_next = '0;
              entries_next  = '0;
            end
            default: begin
              done_next     = 1'b1;
              status_next   = ST_NOT_FOUND;
              position_next = '0;
              entries_next  = ENTRIES_W'(fill);
            end
          endcase
        end
      end
      S_INS_SCAN: begin
        nb_next    = keep_flag;
        state_next = S_INS_MOVE;
      end
      S_INS_MOVE: begin
        fill_next     = fill + CW'(1);
        done_next     = 1'b1;
        status_next   = ST_INSERTED;
        position_next = POS_W'(ins_pos);
        entries_next  = ENTRIES_W'(fill + CW'(1));
        state_next    = S_IDLE;
      end
      S_SEARCH: begin
        if (e_after) begin
          high_next = mid_w - SW'(1);
        end else if (v_after) begin
          low_next = mid_w + SW'(1);
        end else begin
          done_next     = 1'b1;
          status_next   = ST_FOUND;
          position_next = POS_W'(mid);
          entries_next  = ENTRIES_W'(fill);
          state_next    = S_IDLE;
        end
        if ((e_after || v_after) && (low_next > high_next)) begin
          done_next     = 1'b1;
          status_next   = ST_NOT_FOUND;
          position_next = '0;
          entries_next  = ENTRIES_W'(fill);
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
